FILE: rtl/sprd_pkg.sv
package sprd_pkg;

   localparam int PACKET_LEN_DEF = 43;
   localparam int BYTE_W         = 8;
   localparam int ELEMENTS       = 9;
   localparam int ELEM_W         = 4;
   localparam int WORD_W         = 32;
   localparam int RSP_TDATA_W    = 40;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start_packet;  // write the header byte at position 0, fill becomes 1
      logic store_byte;    // append the received byte, fill advances
      logic clear_walk;    // walk index and running sum to zero
      logic set_idx_one;   // walk index to one, element counter to zero
      logic rd_en;         // read the store at the current walk position
      logic acc_sum;       // fold the read byte into the checksum
      logic shift_word;    // shift the read byte into the element word
      logic advance;       // walk index plus one
      logic resync;        // restart the packet at the current walk position
      logic emit;          // load the output register with the element word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic byte_is_hdr;   // received byte equals the header value
      logic fill_last;     // one byte missing to a full packet
      logic idx_last;      // walk index at the last packet position
      logic word_last;     // walk index at the last byte of an element
      logic rd_is_hdr;     // read byte equals the header value
      logic sum_ok;        // checksum equals the trailing word
      logic elem_last;     // element counter at the last element
      logic out_free;      // output register can take a new element
   } status_type;

endpackage

FILE: rtl/sprd_ram.sv
module sprd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 43
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sprd_datapath.sv
module sprd_datapath #(
   parameter int PACKET_LEN = sprd_pkg::PACKET_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sprd_pkg::BYTE_W-1:0]      csr_wr_data,
   input  logic [sprd_pkg::BYTE_W-1:0]      req_tdata,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [sprd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  sprd_pkg::cmd_type                cmd,
   output sprd_pkg::status_type             status
);

   localparam int AW = $clog2(PACKET_LEN);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] LEN_C   = CW'(PACKET_LEN);
   localparam logic [CW-1:0] LAST_C  = CW'(PACKET_LEN - 1);
   localparam logic [CW-1:0] HI_C    = CW'(PACKET_LEN - 2);
   localparam logic [sprd_pkg::ELEM_W-1:0] ELAST_C =
      sprd_pkg::ELEM_W'(sprd_pkg::ELEMENTS - 1);

   // Logical packet position to physical store address; the store is a ring
   // starting at base_ff so that a resync needs no data movement.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] k);
      logic [CW-1:0] s;
      s = {1'b0, b} + k;
      if (s >= LEN_C) begin
         s = s - LEN_C;
      end
      return s[AW-1:0];
   endfunction

   logic [sprd_pkg::BYTE_W-1:0] header_ff;
   logic [AW-1:0]               base_ff, base_in;
   logic [CW-1:0]               fill_ff, fill_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [15:0]                 sum_ff, sum_in;
   logic [sprd_pkg::BYTE_W-1:0] given_hi_ff, given_lo_ff;
   logic [sprd_pkg::WORD_W-1:0] word_ff;
   logic [sprd_pkg::ELEM_W-1:0] elem_ff, elem_in;
   logic                        out_valid_ff, out_valid_in;
   logic [sprd_pkg::ELEM_W-1:0] out_index_ff;
   logic [sprd_pkg::WORD_W-1:0] out_value_ff;
   logic                        out_last_ff;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [AW-1:0]               rd_addr;
   logic [sprd_pkg::BYTE_W-1:0] rd_data;

   assign wr_en   = cmd.start_packet | cmd.store_byte;
   assign wr_addr = cmd.start_packet ? '0 : phys(base_ff, fill_ff);
   assign rd_addr = phys(base_ff, idx_ff);

   sprd_ram #(
      .WIDTH (sprd_pkg::BYTE_W),
      .DEPTH (PACKET_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      base_in = base_ff;
      fill_in = fill_ff;
      if (cmd.start_packet) begin
         base_in = '0;
         fill_in = CW'(1);
      end else if (cmd.store_byte) begin
         fill_in = fill_ff + CW'(1);
      end else if (cmd.resync) begin
         base_in = rd_addr;
         fill_in = LEN_C - idx_ff;
      end

      idx_in = idx_ff;
      if (cmd.clear_walk) begin
         idx_in = '0;
      end else if (cmd.set_idx_one) begin
         idx_in = CW'(1);
      end else if (cmd.advance) begin
         idx_in = idx_ff + CW'(1);
      end

      sum_in = sum_ff;
      if (cmd.clear_walk) begin
         sum_in = '0;
      end else if (cmd.acc_sum && idx_ff < HI_C) begin
         sum_in = sum_ff + {8'd0, rd_data};
      end

      elem_in = elem_ff;
      if (cmd.set_idx_one) begin
         elem_in = '0;
      end else if (cmd.emit) begin
         elem_in = elem_ff + sprd_pkg::ELEM_W'(1);
      end

      out_valid_in = out_valid_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         base_ff      <= '0;
         fill_ff      <= '0;
         idx_ff       <= '0;
         elem_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            header_ff <= csr_wr_data;
         end
         base_ff      <= base_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         elem_ff      <= elem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.acc_sum && idx_ff == HI_C) begin
         given_hi_ff <= rd_data;
      end
      if (cmd.acc_sum && idx_ff == LAST_C) begin
         given_lo_ff <= rd_data;
      end
      if (cmd.shift_word) begin
         word_ff <= {word_ff[sprd_pkg::WORD_W-sprd_pkg::BYTE_W-1:0], rd_data};
      end
      if (cmd.emit) begin
         out_index_ff <= elem_ff;
         out_value_ff <= word_ff;
         out_last_ff  <= (elem_ff == ELAST_C);
      end
   end

   assign status.byte_is_hdr = (req_tdata == header_ff);
   assign status.fill_last   = (fill_ff == LAST_C);
   assign status.idx_last    = (idx_ff == LAST_C);
   assign status.word_last   = (idx_ff[1:0] == 2'd0);
   assign status.rd_is_hdr   = (rd_data == header_ff);
   assign status.sum_ok      = (sum_ff == {given_hi_ff, given_lo_ff});
   assign status.elem_last   = (elem_ff == ELAST_C);
   assign status.out_free    = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_value_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_C)
      else $error("fill count beyond packet length");

   a_base_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, base_ff} < LEN_C)
      else $error("ring base outside the store");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_tready))
      else $error("element loaded over a pending result");

   a_elem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> elem_ff != '0 && elem_ff <= sprd_pkg::ELEM_W'(sprd_pkg::ELEMENTS))
      else $error("element counter out of range");

endmodule

FILE: rtl/sprd_ctrl.sv
module sprd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sprd_pkg::status_type status,
   output sprd_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_USE,
      ST_SUM_CHK,
      ST_SRCH_RD,
      ST_SRCH_USE,
      ST_EMIT_RD,
      ST_EMIT_USE,
      ST_EMIT_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      collecting_ff, collecting_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      collecting_in = collecting_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!collecting_ff) begin
                  if (status.byte_is_hdr) begin
                     cmd.start_packet = 1'b1;
                     collecting_in    = 1'b1;
                  end
               end else begin
                  cmd.store_byte = 1'b1;
                  if (status.fill_last) begin
                     cmd.clear_walk = 1'b1;
                     state_in       = ST_SUM_RD;
                  end
               end
            end
         end
         ST_SUM_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SUM_USE;
         end
         ST_SUM_USE: begin
            cmd.acc_sum = 1'b1;
            cmd.advance = 1'b1;
            state_in    = status.idx_last ? ST_SUM_CHK : ST_SUM_RD;
         end
         ST_SUM_CHK: begin
            cmd.set_idx_one = 1'b1;
            state_in        = status.sum_ok ? ST_EMIT_RD : ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SRCH_USE;
         end
         ST_SRCH_USE: begin
            priority if (status.rd_is_hdr) begin
               cmd.resync = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.idx_last) begin
               collecting_in = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT_USE;
         end
         ST_EMIT_USE: begin
            cmd.shift_word = 1'b1;
            cmd.advance    = 1'b1;
            state_in       = status.word_last ? ST_EMIT_OUT : ST_EMIT_RD;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.elem_last) begin
                  collecting_in = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         collecting_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         collecting_ff <= collecting_in;
      end
   end

   a_full_starts_sum: assert property (@(posedge clock) disable iff (reset)
      accept && collecting_ff && status.fill_last |=> state_ff == ST_SUM_RD)
      else $error("full packet did not start the checksum walk");

   a_emit_only_out: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == ST_EMIT_OUT && status.out_free)
      else $error("element emitted outside the output step");

   a_walk_keeps_collecting: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> collecting_ff)
      else $error("packet walk while hunting");

endmodule

FILE: rtl/sensor_packet_resync_deframer_unit.sv
// Serial sensor packet deframer.
//
// Bytes from the serial receiver enter on the req_ stream, one per transfer.
// While hunting, bytes are dropped until one equals the header value written
// through csr_wr_en / csr_wr_data. From there PACKET_LEN bytes are collected
// into a ring store. A full packet is checked: the 16-bit wrapping sum of all
// bytes but the last two must equal the big-endian trailing word. A good packet
// yields nine transfers on the rsp_ stream, the big-endian words of bytes 1 to
// 36 as matrix elements 0 to 8, with rsp_tlast on the ninth. A bad packet is
// restarted at the first later header byte found in the store, or dropped.
//
// A byte that does not complete a packet leaves req_tready high. The byte that
// completes one holds req_tready low while the single store read port is
// walked: first over the whole packet for the checksum, then over bytes 1 to
// 36 for the elements or from byte 1 on for the header search. The last
// element sits in the output register while new bytes are already taken. A
// stalled receiver holds each element and stops the walk until the output
// register frees. Reset clears the control state, the header value to zero,
// and returns the block to hunting.
module sensor_packet_resync_deframer_unit #(
   parameter int PACKET_LEN = sprd_pkg::PACKET_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sprd_pkg::BYTE_W-1:0]      csr_wr_data,   // header_value
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sprd_pkg::BYTE_W-1:0]      req_tdata,     // rx_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [3:0] element_index, [35:4] element_value, [39:36] zero
   output logic [sprd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast      // last_element
);

   sprd_pkg::cmd_type    cmd;
   sprd_pkg::status_type status;

   // The sequencer decides what the datapath does each cycle.
   sprd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the store, the walk counters, the checksum and the
   // output register.
   sprd_datapath #(
      .PACKET_LEN (PACKET_LEN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
